### rtl/cscd_pkg.sv
// Shared types, constants, code tables and helper functions for the Cyrillic charset detector.
package cscd_pkg;

	// Score counter width, one counter per reading
	localparam int SCORE_WIDTH = 32;
	localparam int NUM_READ    = 4;
	// One vowel point plus an 8-bit word bonus needs nine bits
	localparam int BONUS_W     = 8;
	localparam int INC_W       = BONUS_W + 1;
	localparam int SUM_W       = ((SCORE_WIDTH > INC_W) ? SCORE_WIDTH : INC_W) + 1;

	localparam logic [BONUS_W-1:0] BONUS_RESET = 8'd10;

	// Reading codes, also the reported result
	typedef enum logic [1:0] {
		ENC_WIN  = 2'd0,
		ENC_DOS  = 2'd1,
		ENC_KOI  = 2'd2,
		ENC_UTF8 = 2'd3
	} enc_t;

	typedef logic [SCORE_WIDTH-1:0] score_t;

	// Per-item score increments, registered after classification
	typedef struct packed {
		logic                          valid;
		logic                          last;
		logic [NUM_READ-1:0][INC_W-1:0] inc;
	} incr_t;

	// Final scores of a finished text
	typedef struct packed {
		logic                    valid;
		logic [NUM_READ-1:0][SCORE_WIDTH-1:0] score;
	} final_t;

	// CP866 high half to CP1251
	localparam logic [7:0] DOS_ROM [128] = '{
		8'hC0,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,
		8'hC8,8'hC9,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,
		8'hD0,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,
		8'hD8,8'hD9,8'hDA,8'hDB,8'hDC,8'hDD,8'hDE,8'hDF,
		8'hE0,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,
		8'hE8,8'hE9,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,8'hEF,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,
		8'hF8,8'hF9,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE,8'hFF,
		8'hA8,8'hB8,8'hAA,8'hBA,8'hAF,8'hBF,8'hA1,8'hA2,
		8'hB0,8'h95,8'hB7,8'h00,8'hB9,8'hA4,8'h00,8'hA0
	};

	// KOI8-R high half to CP1251
	localparam logic [7:0] KOI_ROM [128] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h95,8'h00,8'h00,
		8'h00,8'h00,8'hA0,8'h00,8'hB0,8'h00,8'hB7,8'h00,
		8'h00,8'h00,8'h00,8'hB8,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'hA8,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hA9,
		8'hFE,8'hE0,8'hE1,8'hF6,8'hE4,8'hE5,8'hF4,8'hE3,
		8'hF5,8'hE8,8'hE9,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,
		8'hEF,8'hFF,8'hF0,8'hF1,8'hF2,8'hF3,8'hE6,8'hE2,
		8'hFC,8'hFB,8'hE7,8'hF8,8'hFD,8'hF9,8'hF7,8'hFA,
		8'hDE,8'hC0,8'hC1,8'hD6,8'hC4,8'hC5,8'hD4,8'hC3,
		8'hD5,8'hC8,8'hC9,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,
		8'hCF,8'hDF,8'hD0,8'hD1,8'hD2,8'hD3,8'hC6,8'hC2,
		8'hDC,8'hDB,8'hC7,8'hD8,8'hDD,8'hD9,8'hD7,8'hDA
	};

	// CP1251 lower-casing of Cyrillic and ASCII capitals
	function automatic logic [7:0] lower1251(input logic [7:0] c);
		logic up;
		up = (c[7:5] == 3'b110) || (c >= 8'h41 && c <= 8'h5A);
		return up ? (c | 8'h20) : c;
	endfunction

	function automatic logic is_vowel(input logic [7:0] c);
		return c == 8'hE0 || c == 8'hEE || c == 8'hE5 || c == 8'hE8;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return c == 8'hF3 || c == 8'hFF || c == 8'hE8 || c == 8'hEE ||
		       c == 8'hE0 || c == 8'hE2 || c == 8'hEA || c == 8'hF1;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h0D || c == 8'h0A || c == 8'h09;
	endfunction

endpackage

### rtl/cyrillic_charset_detector_top.sv
// Top level of the Cyrillic charset detector.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------------
//   s_*      | in  | s_tvalid/s_tready  | s_tdata[7:0] text_byte, s_tlast req_type
//   m_*      | out | m_tvalid/m_tready  | m_tdata[1:0] detected, [7:2] zero
//   cfg_*    | in  | cfg_valid/cfg_ready| cfg_data[7:0] word_bonus
//
// One request per cycle while s_tready is high: input register, classify stage, score stage, result register.
// An end-of-text request passes the input register, classify and score stages and result register to m_tvalid.
// Reset clears scores and history and sets word_bonus to 10; the end request clears
// scores and history again.
// s_tready drops only while a result waits in the result register and another
// finished result is queued behind it.
module cyrillic_charset_detector_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,   // req_type: end of text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [1:0] detected, [7:2] zero
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data   // [7:0] word_bonus
);
	import cscd_pkg::*;

	logic               adv;
	logic               hold;
	logic               valid_s1;
	logic               last_s1;
	logic [7:0]         byte_s1;
	logic [BONUS_W-1:0] bonus_q;
	logic [1:0]         detected;
	incr_t              incr_s2;
	final_t             fin_s3;

	assign adv       = !hold;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// Word bonus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bonus_q <= BONUS_RESET;
		end else if (cfg_valid) begin
			bonus_q <= cfg_data[BONUS_W-1:0];
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			last_s1 <= s_tlast;
			byte_s1 <= s_tdata;
		end
	end

	cscd_classify u_cls (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.last_s1  (last_s1),
		.byte_s1  (byte_s1),
		.bonus    (bonus_q),
		.incr_s2  (incr_s2)
	);

	cscd_score u_scr (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.incr_s2 (incr_s2),
		.fin_s3  (fin_s3)
	);

	cscd_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_s3    (fin_s3),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.detected  (detected),
		.hold      (hold)
	);

	assign m_tdata = {6'b0, detected};

endmodule

### rtl/cscd_classify.sv
// Byte classification: lower-casing, table lookups, vowel and one-letter word increments.
module cscd_classify (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          valid_s1,
	input  logic                          last_s1,
	input  logic [7:0]                    byte_s1,
	input  logic [cscd_pkg::BONUS_W-1:0]  bonus,
	output cscd_pkg::incr_t               incr_s2
);
	import cscd_pkg::*;

	logic [7:0]          lc;
	logic [7:0]          dc;
	logic [7:0]          kc;
	logic                hi;
	logic                sp;
	logic                fire;
	logic [NUM_READ-1:0] vowel;
	logic [NUM_READ-1:0] word_now;
	logic [NUM_READ-1:0] word_q;
	logic                prev_sp_q;
	logic                two_back_q;
	logic [NUM_READ-1:0][INC_W-1:0] inc;

	// Lower-case the byte and read its DOS and KOI meanings
	always_comb begin
		hi = byte_s1[7];
		lc = hi ? lower1251(byte_s1) : byte_s1;
		dc = lower1251(DOS_ROM[lc[6:0]]);
		kc = lower1251(KOI_ROM[lc[6:0]]);
		sp = is_ws(lc);

		vowel[ENC_WIN]  = hi && is_vowel(lc);
		vowel[ENC_DOS]  = hi && is_vowel(dc);
		vowel[ENC_KOI]  = hi && is_vowel(kc);
		vowel[ENC_UTF8] = hi && (lc == 8'hF0 || lc == 8'hF1);

		// One-letter word flags of this byte, used when the next byte closes the word
		word_now[ENC_WIN]  = is_word(lc);
		word_now[ENC_DOS]  = hi && is_word(dc);
		word_now[ENC_KOI]  = hi && is_word(kc);
		word_now[ENC_UTF8] = 1'b0;

		// End of text acts as closing whitespace
		fire = two_back_q && (last_s1 || sp);

		for (int k = 0; k < NUM_READ; k++) begin
			inc[k] = INC_W'(vowel[k] && !last_s1)
				+ ((fire && word_q[k]) ? INC_W'(bonus) : INC_W'(0));
		end
	end

	// Track the last two bytes; clear at end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q     <= '0;
			prev_sp_q  <= 1'b0;
			two_back_q <= 1'b0;
		end else if (adv && valid_s1) begin
			if (last_s1) begin
				word_q     <= '0;
				prev_sp_q  <= 1'b0;
				two_back_q <= 1'b0;
			end else begin
				word_q     <= word_now;
				prev_sp_q  <= sp;
				two_back_q <= prev_sp_q;
			end
		end
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			incr_s2 <= '0;
		end else if (adv) begin
			incr_s2.valid <= valid_s1;
			incr_s2.last  <= last_s1;
			incr_s2.inc   <= inc;
		end
	end

endmodule

### rtl/cscd_score.sv
// Saturating score counters for the four readings.
module cscd_score (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  cscd_pkg::incr_t  incr_s2,
	output cscd_pkg::final_t fin_s3
);
	import cscd_pkg::*;

	score_t                        score_q [NUM_READ];
	logic [NUM_READ-1:0][SCORE_WIDTH-1:0] next_score;
	logic [SUM_W-1:0]              sum [NUM_READ];

	// Add with saturation at the all-ones value
	always_comb begin
		for (int k = 0; k < NUM_READ; k++) begin
			sum[k] = SUM_W'(score_q[k]) + SUM_W'(incr_s2.inc[k]);
			next_score[k] = (sum[k][SUM_W-1:SCORE_WIDTH] != '0) ? '1
				: sum[k][SCORE_WIDTH-1:0];
		end
	end

	// Accumulate; hand off and clear at end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_READ; k++) begin
				score_q[k] <= '0;
			end
			fin_s3 <= '0;
		end else if (adv) begin
			fin_s3.valid <= incr_s2.valid && incr_s2.last;
			if (incr_s2.valid) begin
				for (int k = 0; k < NUM_READ; k++) begin
					score_q[k] <= incr_s2.last ? '0 : next_score[k];
				end
			end
			// Final scores payload
			if (incr_s2.valid && incr_s2.last) begin
				fin_s3.score <= next_score;
			end
		end
	end

endmodule

### rtl/cscd_pick.sv
// Highest-score selection with ties to the lower code, and the result register.
module cscd_pick (
	input  logic             clk,
	input  logic             arst_n,
	input  cscd_pkg::final_t fin_s3,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [1:0]       detected,
	output logic             hold
);
	import cscd_pkg::*;

	logic   out_valid_q;
	enc_t   det_q;
	enc_t   best;
	score_t s0, s1, s2, s3;
	logic   load;

	// Pairwise compares in parallel, first maximum wins
	always_comb begin
		s0 = fin_s3.score[ENC_WIN];
		s1 = fin_s3.score[ENC_DOS];
		s2 = fin_s3.score[ENC_KOI];
		s3 = fin_s3.score[ENC_UTF8];
		if (s0 >= s1 && s0 >= s2 && s0 >= s3) begin
			best = ENC_WIN;
		end else if (s1 > s0 && s1 >= s2 && s1 >= s3) begin
			best = ENC_DOS;
		end else if (s2 > s0 && s2 > s1 && s2 >= s3) begin
			best = ENC_KOI;
		end else begin
			best = ENC_UTF8;
		end
		load = fin_s3.valid && (!out_valid_q || out_ready);
		hold = fin_s3.valid && out_valid_q && !out_ready;
	end

	// Result register: load a new result or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			det_q <= best;
		end
	end

	assign out_valid = out_valid_q;
	assign detected  = det_q;

endmodule

### rtl/cscd_checker.sv
// Port-level checks for the Cyrillic charset detector, bound to the top level.
module cscd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [7:0] cfg_data
);
	logic [2:0] pend_q;
	logic       end_in;
	logic       res_out;

	assign end_in  = s_tvalid && s_tready && s_tlast;
	assign res_out = m_tvalid && m_tready;

	// Count end requests whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(end_in) - 3'(res_out);
		end
	end

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Never show a result without a pending end request
	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("result without end request");

	// At most four end requests in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("too many pending results");

	// Input is only held back behind a waiting result
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready && m_tdata[7:2] == 6'd0 || !m_tvalid && s_tready)
		else $error("input stalled with empty result register");

endmodule

bind cyrillic_charset_detector_top cscd_checker u_chk (.*);
